[hw/rtl/ldf_pkg.sv]
// Shared types and constants for the line / length-prefixed deframer.
// No dependencies; every file of the block but the two channel interfaces imports this package.
package ldf_pkg;

  // Register widths and indexes on the configuration port
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LINE = 2'd2;

  // Reset values of the registers
  localparam logic RST_FRAME_MODE = 1'b1;
  localparam logic [23:0] RST_MAX_PAYLOAD = 24'd65536;
  localparam logic [15:0] RST_MAX_LINE = 16'd4096;

  // Frame modes
  localparam logic MODE_LINE = 1'b0;
  localparam logic MODE_PACKET = 1'b1;

  // Byte codes
  localparam logic [7:0] LF_CODE = 8'h0A;
  localparam logic [7:0] CR_CODE = 8'h0D;

  // Length header size and last header byte index
  localparam int HeaderBytes = 4;
  localparam logic [1:0] HDR_LAST = 2'(HeaderBytes - 1);

  // Result status codes
  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_BAD_LEN = 2'd1;
  localparam logic [1:0] STAT_LINE_LONG = 2'd2;

  // Result queue geometry
  localparam int QDepth = 4;
  localparam int QAw = $clog2(QDepth);

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [1:0] status;
  } result_t;

  // Up to two results pushed by the front end in one cycle
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic         empty;
    logic [QAw:0] count;
  } q_stat_t;

endpackage

[hw/rtl/ldf_in_if.sv]
// Input channel of the deframer: valid/ready plus one received byte.
// Depends on nothing.
interface ldf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       new_connection;

  modport source (output valid, output rx_byte, output new_connection, input ready);
  modport sink (input valid, input rx_byte, input new_connection, output ready);
endinterface

[hw/rtl/ldf_out_if.sv]
// Result channel of the deframer: valid/ready plus one result item.
// Depends on nothing.
interface ldf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       frame_end;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_valid, output frame_end,
                  output status, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input frame_end,
                input status, output ready);
endinterface

[hw/rtl/ldf_front.sv]
// Front end: configuration registers, parser state and per-byte classification.
// Depends on ldf_pkg; pushes zero, one or two results per byte into ldf_queue.
module ldf_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [ldf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ldf_pkg::CfgDataW-1:0] cfg_data,
  input  logic                    acc_en,
  input  logic [7:0]              rx_byte,
  input  logic                    new_connection,
  output ldf_pkg::push_t          push
);
  import ldf_pkg::*;

  // Configuration registers
  logic        frame_mode_r;
  logic [23:0] max_payload_r;
  logic [15:0] max_line_r;

  // Parser state
  logic [1:0]  header_count_r, header_count_nxt;
  logic [23:0] length_acc_r, length_acc_nxt;
  logic [23:0] payload_rem_r, payload_rem_nxt;
  logic        held_cr_r, held_cr_nxt;
  logic [15:0] line_length_r, line_length_nxt;
  logic        closed_r, closed_nxt;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_mode_r  <= RST_FRAME_MODE;
      max_payload_r <= RST_MAX_PAYLOAD;
      max_line_r    <= RST_MAX_LINE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_MODE:  frame_mode_r  <= cfg_data[0];
        CFG_MAX_PAYLOAD: max_payload_r <= cfg_data;
        CFG_MAX_LINE:    max_line_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Per-byte next state and results
  always_comb begin
    result_t     res [2];
    logic [1:0]  n;
    logic [15:0] len;
    logic        err;
    logic [31:0] hdr_len;

    header_count_nxt = header_count_r;
    length_acc_nxt   = length_acc_r;
    payload_rem_nxt  = payload_rem_r;
    held_cr_nxt      = held_cr_r;
    line_length_nxt  = line_length_r;
    closed_nxt       = closed_r;
    res[0]  = '0;
    res[1]  = '0;
    n       = 2'd0;
    len     = '0;
    err     = 1'b0;
    hdr_len = '0;

    if (acc_en) begin
      // new connection wipes state before the byte is looked at
      if (new_connection) begin
        header_count_nxt = '0;
        length_acc_nxt   = '0;
        payload_rem_nxt  = '0;
        held_cr_nxt      = 1'b0;
        line_length_nxt  = '0;
        closed_nxt       = 1'b0;
      end

      if (!closed_nxt) begin
        if (frame_mode_r == MODE_LINE) begin
          if (rx_byte == LF_CODE) begin
            // end of line, no data byte
            held_cr_nxt     = 1'b0;
            line_length_nxt = '0;
            res[0]          = '{8'd0, 1'b0, 1'b1, STAT_OK};
            n               = 2'd1;
          end else begin
            len = line_length_nxt;
            // release a held CR ahead of this byte
            if (held_cr_nxt) begin
              held_cr_nxt = 1'b0;
              if (len >= max_line_r) begin
                res[0]     = '{8'd0, 1'b0, 1'b0, STAT_LINE_LONG};
                closed_nxt = 1'b1;
                err        = 1'b1;
              end else begin
                res[0] = '{CR_CODE, 1'b1, 1'b0, STAT_OK};
                len    = len + 16'd1;
              end
              n = 2'd1;
            end
            if (!err) begin
              if (rx_byte == CR_CODE) begin
                held_cr_nxt = 1'b1;
              end else begin
                if (len >= max_line_r) begin
                  res[n[0]]  = '{8'd0, 1'b0, 1'b0, STAT_LINE_LONG};
                  closed_nxt = 1'b1;
                end else begin
                  res[n[0]] = '{rx_byte, 1'b1, 1'b0, STAT_OK};
                  len       = len + 16'd1;
                end
                n = n + 2'd1;
              end
            end
            line_length_nxt = len;
          end
        end else begin
          if (payload_rem_nxt == '0) begin
            // header phase, little-endian length
            if (header_count_nxt != HDR_LAST) begin
              case (header_count_nxt)
                2'd0:    length_acc_nxt[7:0]   = rx_byte;
                2'd1:    length_acc_nxt[15:8]  = rx_byte;
                default: length_acc_nxt[23:16] = rx_byte;
              endcase
              header_count_nxt = header_count_nxt + 2'd1;
            end else begin
              hdr_len          = {rx_byte, length_acc_nxt};
              header_count_nxt = '0;
              length_acc_nxt   = '0;
              if (hdr_len == '0 || hdr_len > {8'd0, max_payload_r}) begin
                closed_nxt = 1'b1;
                res[0]     = '{8'd0, 1'b0, 1'b0, STAT_BAD_LEN};
                n          = 2'd1;
              end else begin
                payload_rem_nxt = hdr_len[23:0];
              end
            end
          end else begin
            // payload byte, mark the last one
            res[0] = '{rx_byte, 1'b1, (payload_rem_nxt == 24'd1), STAT_OK};
            payload_rem_nxt = payload_rem_nxt - 24'd1;
            n = 2'd1;
          end
        end
      end
    end

    push.n  = n;
    push.r0 = res[0];
    push.r1 = res[1];
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r <= '0;
      length_acc_r   <= '0;
      payload_rem_r  <= '0;
      held_cr_r      <= 1'b0;
      line_length_r  <= '0;
      closed_r       <= 1'b0;
    end else begin
      header_count_r <= header_count_nxt;
      length_acc_r   <= length_acc_nxt;
      payload_rem_r  <= payload_rem_nxt;
      held_cr_r      <= held_cr_nxt;
      line_length_r  <= line_length_nxt;
      closed_r       <= closed_nxt;
    end
  end

endmodule

[hw/rtl/ldf_queue.sv]
// Short result queue between front and back end; takes up to two results a cycle.
// Depends on ldf_pkg.
module ldf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  ldf_pkg::push_t    push,
  input  logic              pop,
  output ldf_pkg::result_t  head,
  output ldf_pkg::q_stat_t  stat
);
  import ldf_pkg::*;

  result_t        mem_r [QDepth];
  logic [QAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAw:0]   count_r;
  logic [QAw-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + QAw'(1);

  // Storage: first result at the write pointer, second right after it
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QAw'(push.n);
      rd_ptr_r <= rd_ptr_r + QAw'(pop);
      count_r  <= count_r + (QAw+1)'(push.n) - (QAw+1)'(pop);
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule

[hw/rtl/ldf_back.sv]
// Back end: moves queued results into the output register and onto the channel.
// Depends on ldf_pkg.
module ldf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ldf_pkg::result_t head,
  input  ldf_pkg::q_stat_t stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output ldf_pkg::result_t out_data
);
  import ldf_pkg::*;

  logic    out_valid_r;
  result_t out_data_r;

  // Refill when the register is empty or its result is being taken
  assign pop = !stat.empty && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= head;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/line_or_length_prefixed_deframer.sv]
// Byte-stream deframer, one received byte per request at up to one request per clock.
// Line mode emits each data byte, drops a CR right before LF and gives an end-of-line
// result on LF; packet mode reads a 4-byte little-endian length and passes the payload,
// marking the last byte. Each byte is parsed in the cycle it is taken and yields zero,
// one or two results into a four-entry queue; results leave one per clock unless
// stalled, from a registered output. A byte is taken whenever at least two queue
// entries are free, so the input stalls only when the output side falls behind (a
// released CR plus a data byte produce two results from one byte). After a bad length
// or an overlong line the stream is dropped until a request with new_connection set.
// Depends on ldf_pkg, the channel interfaces, ldf_front, ldf_queue and ldf_back.
module line_or_length_prefixed_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ldf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ldf_pkg::CfgDataW-1:0] cfg_data,
  ldf_in_if.sink                       in_chan,
  ldf_out_if.source                    out_chan
);
  import ldf_pkg::*;

  push_t   push;
  result_t head;
  result_t out_data;
  q_stat_t stat;
  logic    pop;
  logic    in_acc;

  // Room for the worst case of two results
  assign in_chan.ready = (stat.count <= (QAw+1)'(QDepth - 2));
  assign in_acc        = in_chan.valid && in_chan.ready;

  ldf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .acc_en         (in_acc),
    .rx_byte        (in_chan.rx_byte),
    .new_connection (in_chan.new_connection),
    .push           (push)
  );

  ldf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  ldf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign out_chan.out_byte   = out_data.out_byte;
  assign out_chan.byte_valid = out_data.byte_valid;
  assign out_chan.frame_end  = out_data.frame_end;
  assign out_chan.status     = out_data.status;

endmodule

[test/ldf_deframer_checker.sv]
// Checker for the line / length-prefixed deframer: predicts results per accepted byte.
// Watches the config port and both channels, compares results in order.
// Depends on ldf_pkg, ldf_in_if and ldf_out_if.
module ldf_deframer_checker
  import ldf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  ldf_in_if                   in_mon,
  ldf_out_if                  out_mon,
  output int                  fail_count,
  output int                  pending
);

  // Shadow registers
  logic        mode;
  logic [23:0] max_pay;
  logic [15:0] max_len;

  // Parser state
  logic [2:0]  hdr_cnt;
  logic [31:0] len_acc;
  logic [23:0] pay_left;
  logic        cr_held;
  logic [15:0] line_len;
  logic        closed;

  result_t frames_q[$];
  int      errors;

  function automatic void push_result(input logic [7:0] b, input logic vld,
                                      input logic last, input logic [1:0] st);
    frames_q.push_back('{out_byte: b, byte_valid: vld, frame_end: last, status: st});
  endfunction

  function automatic void clear_parser();
    hdr_cnt  = '0;
    len_acc  = '0;
    pay_left = '0;
    cr_held  = 1'b0;
    line_len = '0;
    closed   = 1'b0;
  endfunction

  // One line data byte, or the overflow error once the line is full
  function automatic bit emit_line_byte(input logic [7:0] b);
    if (line_len >= max_len) begin
      push_result(8'h00, 1'b0, 1'b0, STAT_LINE_LONG);
      closed = 1'b1;
      return 1'b0;
    end
    push_result(b, 1'b1, 1'b0, STAT_OK);
    line_len = line_len + 16'd1;
    return 1'b1;
  endfunction

  task automatic deframe_byte(input logic [7:0] b, input logic nc);
    logic [31:0] hdr_len;
    bit          ok;
    if (nc) clear_parser();
    if (closed) return;
    if (mode == MODE_LINE) begin
      if (b == LF_CODE) begin
        cr_held  = 1'b0;
        line_len = '0;
        push_result(8'h00, 1'b0, 1'b1, STAT_OK);
      end else begin
        ok = 1'b1;
        // held CR goes out as data unless LF follows
        if (cr_held) begin
          cr_held = 1'b0;
          ok = emit_line_byte(CR_CODE);
        end
        if (ok) begin
          if (b == CR_CODE) cr_held = 1'b1;
          else ok = emit_line_byte(b);
        end
      end
    end else if (pay_left == '0) begin
      // header phase, little-endian length
      len_acc = len_acc | (32'(b) << {hdr_cnt[1:0], 3'b000});
      hdr_cnt = {1'b0, hdr_cnt[1:0]} + 3'd1;
      if (hdr_cnt == 3'(HeaderBytes)) begin
        hdr_len = len_acc;
        hdr_cnt = '0;
        len_acc = '0;
        if (hdr_len == '0 || hdr_len > 32'(max_pay)) begin
          closed = 1'b1;
          push_result(8'h00, 1'b0, 1'b0, STAT_BAD_LEN);
        end else begin
          pay_left = hdr_len[23:0];
        end
      end
    end else begin
      pay_left = pay_left - 24'd1;
      push_result(b, 1'b1, pay_left == '0, STAT_OK);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    bit      bad;
    if (!rst_n) begin
      mode    = RST_FRAME_MODE;
      max_pay = RST_MAX_PAYLOAD;
      max_len = RST_MAX_LINE;
      clear_parser();
      frames_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_MODE:  mode = cfg_data[0];
          CFG_MAX_PAYLOAD: max_pay = cfg_data[23:0];
          CFG_MAX_LINE:    max_len = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) deframe_byte(in_mon.rx_byte, in_mon.new_connection);
      // compare each result with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (frames_q.size() == 0) begin
          $error("unexpected result: out_byte %0h byte_valid %0b frame_end %0b status %0d",
                 out_mon.out_byte, out_mon.byte_valid, out_mon.frame_end, out_mon.status);
          errors++;
        end else begin
          want = frames_q.pop_front();
          bad  = 1'b0;
          if (out_mon.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_mon.out_byte);
            bad = 1'b1;
          end
          if (out_mon.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_mon.byte_valid);
            bad = 1'b1;
          end
          if (out_mon.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, out_mon.frame_end);
            bad = 1'b1;
          end
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            bad = 1'b1;
          end
          if (bad) errors++;
        end
      end
    end
    fail_count <= errors;
    pending    <= frames_q.size();
  end

endmodule

[test/tb_line_or_length_prefixed_deframer.sv]
// Top of the deframer testbench: clock, reset, register writes, byte stimulus and verdict.
// Depends on ldf_pkg, the channel interfaces, the deframer and ldf_deframer_checker.
module tb_line_or_length_prefixed_deframer;
  import ldf_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ldf_in_if  in_chan ();
  ldf_out_if out_chan ();

  int fail_count;
  int pending;

  // Stimulus-side view of the settings, used only to shape traffic
  logic        cur_mode;
  logic [23:0] cur_max_pay;
  logic [15:0] cur_max_line;

  bit burst;     // no idling on either side while set
  bit hold_req;  // receiver takes one long hold-off when set
  int items_sent;

  // Directed packet sequence {new_connection, byte}: minimal packet, zero length,
  // dropped byte while closed, reopen with a two-byte packet
  localparam logic [8:0] PKT_SCRIPT [16] = '{
    9'h101, 9'h000, 9'h000, 9'h000, 9'h0FF,
    9'h000, 9'h000, 9'h000, 9'h000,
    9'h07E,
    9'h102, 9'h000, 9'h000, 9'h000, 9'h000, 9'h080
  };

  // Directed lines with max_line 2: CR before LF, released CR, empty line,
  // CR after CR, overflow on a released CR, dropped LF, reopen
  localparam logic [8:0] LINE_SCRIPT [14] = '{
    9'h141, {1'b0, CR_CODE}, {1'b0, LF_CODE},
    {1'b0, CR_CODE}, 9'h0FF, {1'b0, LF_CODE}, {1'b0, LF_CODE},
    {1'b0, CR_CODE}, {1'b0, CR_CODE}, {1'b0, CR_CODE}, 9'h000,
    {1'b0, LF_CODE}, 9'h180, {1'b0, LF_CODE}
  };

  line_or_length_prefixed_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  ldf_deframer_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("tb_line_or_length_prefixed_deframer NOT OK");
    $finish;
  end

  // Result receiver: random stall per request, one long hold-off on demand
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = burst ? 0 : $urandom_range(0, 13);
        if (stall > 0) begin
          out_chan.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // Offer one byte after a random gap; returns at the accepting edge with valid high
  task automatic send_byte(input logic [7:0] b, input logic nc);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.rx_byte        <= b;
    in_chan.new_connection <= nc;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  // Let all predicted results drain and the pipeline settle; the first edge lets
  // the count pick up the results of the last accepted byte
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_settings(input logic mode, input logic [23:0] maxp,
                                input logic [15:0] maxl);
    drain();
    write_reg(CFG_FRAME_MODE, CfgDataW'(mode));
    write_reg(CFG_MAX_PAYLOAD, maxp);
    write_reg(CFG_MAX_LINE, CfgDataW'(maxl));
    cur_mode     = mode;
    cur_max_pay  = maxp;
    cur_max_line = maxl;
  endtask

  // Header plus payload; the payload follows only when the length is legal
  task automatic send_packet(input logic [31:0] len, input logic nc);
    for (int i = 0; i < HeaderBytes; i++) send_byte(len[8*i +: 8], (i == 0) ? nc : 1'b0);
    if (len != 0 && len <= 32'(cur_max_pay))
      repeat (len) send_byte(8'($urandom), 1'b0);
  endtask

  // Mostly well-formed frames with random content, some bad ones and noise
  task automatic run_random(input int n_items);
    int          start;
    int          kind;
    int          cap;
    int          n;
    logic [31:0] len;
    logic [7:0]  b;
    bit          reopen;
    bit          fresh;
    start  = items_sent;
    reopen = $urandom_range(0, 1);
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 31) == 0) burst = ~burst;
      kind = $urandom_range(0, 15);
      if (cur_mode == MODE_PACKET) begin
        fresh  = reopen || ($urandom_range(0, 7) == 0);
        reopen = 1'b0;
        if (kind < 11) begin
          cap = (cur_max_pay < 8) ? int'(cur_max_pay) : 8;
          len = $urandom_range(1, cap);
          send_packet(len, fresh);
        end else if (kind == 11) begin
          send_packet(32'(cur_max_pay) + 32'd1, fresh);
          reopen = 1'b1;
        end else if (kind == 12) begin
          send_packet({8'($urandom_range(1, 255)), 24'($urandom)}, fresh);
          reopen = 1'b1;
        end else if (kind == 13) begin
          send_packet(32'd0, fresh);
          reopen = 1'b1;
        end else begin
          // noise, possibly cutting into a frame
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom_range(0, 3) == 0));
          reopen = 1'b1;
        end
      end else begin
        fresh  = reopen || ($urandom_range(0, 3) == 0);
        reopen = 1'b0;
        cap    = (cur_max_line < 6) ? int'(cur_max_line) : 6;
        if (cur_max_line <= 8 && $urandom_range(0, 3) == 0)
          n = int'(cur_max_line) + $urandom_range(0, 2);
        else
          n = $urandom_range(0, cap);
        if (n > int'(cur_max_line)) reopen = 1'b1;
        for (int i = 0; i < n; i++) begin
          b = ($urandom_range(0, 5) == 0) ? CR_CODE : 8'($urandom);
          if (b == LF_CODE) b = 8'h4C;
          send_byte(b, fresh);
          fresh = 1'b0;
        end
        // line ending: LF, CR LF, CR CR LF, or none
        if (kind >= 8 && kind < 12) begin
          send_byte(CR_CODE, fresh);
          fresh = 1'b0;
        end else if (kind == 12) begin
          send_byte(CR_CODE, fresh);
          send_byte(CR_CODE, 1'b0);
          fresh = 1'b0;
        end
        if (kind != 13) send_byte(LF_CODE, fresh);
      end
    end
  endtask

  // Main stimulus
  initial begin
    int waited;
    burst    = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_index              <= CFG_FRAME_MODE;
    cfg_data               <= '0;
    in_chan.valid          <= 1'b0;
    in_chan.rx_byte        <= 8'h00;
    in_chan.new_connection <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    cur_mode     = RST_FRAME_MODE;
    cur_max_pay  = RST_MAX_PAYLOAD;
    cur_max_line = RST_MAX_LINE;

    // directed part, packet mode at reset settings, then line mode
    foreach (PKT_SCRIPT[i]) send_byte(PKT_SCRIPT[i][7:0], PKT_SCRIPT[i][8]);
    apply_settings(MODE_LINE, 24'd5, 16'd2);
    foreach (LINE_SCRIPT[i]) send_byte(LINE_SCRIPT[i][7:0], LINE_SCRIPT[i][8]);

    // random part over several settings, extremes first
    apply_settings(MODE_PACKET, 24'd1, 16'd1);
    run_random(35);
    apply_settings(MODE_LINE, 24'hFFFFFF, 16'd1);
    run_random(35);
    apply_settings(MODE_LINE, 24'($urandom_range(1, 8)), 16'hFFFF);
    run_random(35);

    // back-pressure: receiver holds off while the sender streams full packets
    apply_settings(MODE_PACKET, 24'd8, 16'($urandom_range(1, 6)));
    burst    = 1'b1;
    hold_req = 1'b1;
    repeat (3) send_packet(32'd8, 1'b1);
    drain();
    burst = 1'b0;
    run_random(35);

    apply_settings(MODE_PACKET, 24'hFFFFFF, 16'hFFFF);
    run_random(35);
    apply_settings(MODE_LINE, 24'd3, 16'd2);
    run_random(35);
    for (int p = 0; p < 4; p++) begin
      apply_settings(1'($urandom_range(0, 1)), 24'($urandom_range(1, 8)),
                     16'($urandom_range(1, 6)));
      run_random(35);
    end

    // wind down and give the verdict
    in_chan.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_line_or_length_prefixed_deframer OK");
    end else begin
      $display("tb_line_or_length_prefixed_deframer NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ldf_pkg.sv
hw/rtl/ldf_in_if.sv
hw/rtl/ldf_out_if.sv
hw/rtl/ldf_front.sv
hw/rtl/ldf_queue.sv
hw/rtl/ldf_back.sv
hw/rtl/line_or_length_prefixed_deframer.sv
test/ldf_deframer_checker.sv
test/tb_line_or_length_prefixed_deframer.sv
